// File: hdl/hfm_pkg.sv
package hfm_pkg;

  // Event codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_PING   = 3'd0,
    MODE_FAIL   = 3'd1,
    MODE_ACK    = 3'd2,
    MODE_REMOVE = 3'd3,
    MODE_TICK   = 3'd4
  } mode_t;

  // Result codes carried in the action field
  localparam logic ACT_ERROR = 1'b0;
  localparam logic ACT_ROUND = 1'b1;

  // Width of the external server field and round field
  localparam int ServerW = 4;
  localparam int PingW   = 8;
  localparam int CountW  = 8;

  localparam logic [CountW-1:0] CountTop = '1;

  // One classified event word as it waits in the queue
  typedef struct packed {
    mode_t              op;
    logic [ServerW-1:0] server;
    logic [PingW-1:0]   ping_id;
    logic               ack_ok;
  } cmd_t;

  // Head of the event queue as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

// File: hdl/hfm_front.sv
module hfm_front #(
  parameter int NUM_SERVERS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [2:0]              mode,
  input  logic [3:0]              server_id,
  input  logic [7:0]              ping_id,
  input  logic                    ack_ok,
  output hfm_pkg::queue_head_t    head,
  input  logic                    pop
);
  import hfm_pkg::*;

  localparam int Depth = 2;

  cmd_t       entry [Depth];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic [1:0] count_next;
  logic       accept;
  logic       legal;
  logic       push;
  cmd_t       cmd_in;

  // Classify: drop unused modes and servers beyond the table
  always_comb begin
    legal = 1'b0;
    case (mode)
      MODE_TICK: legal = 1'b1;
      MODE_PING, MODE_FAIL, MODE_ACK, MODE_REMOVE:
        legal = (32'(server_id) < 32'(NUM_SERVERS));
      default: legal = 1'b0;
    endcase
  end

  assign cmd_in   = '{op: mode_t'(mode), server: server_id, ping_id: ping_id, ack_ok: ack_ok};
  assign in_stall = (count == 2'(Depth));
  assign accept   = in_valid && !in_stall;
  assign push     = accept && legal;

  assign count_next = count + {1'b0, push} - {1'b0, pop};

  // Advance queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  // Hold queued words
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= cmd_in;
    end
  end

  assign head.valid = (count != '0);
  assign head.cmd   = entry[rd_ptr];

endmodule

// File: hdl/hfm_back.sv
module hfm_back #(
  parameter int NUM_SERVERS    = 16,
  parameter int ROUND_ID_WIDTH = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  hfm_pkg::queue_head_t head,
  output logic                 pop,
  input  logic [7:0]           fail_limit,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 action,
  output logic [3:0]           server_id_out,
  output logic                 restart,
  output logic [7:0]           round_id,
  output logic                 last
);
  import hfm_pkg::*;

  localparam int IdxW = (NUM_SERVERS > 1) ? $clog2(NUM_SERVERS) : 1;
  localparam int RW   = ROUND_ID_WIDTH;
  localparam int CmpW = (RW > PingW) ? RW : PingW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SERVERS - 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EVAL  = 6'b000010,
    S_SCAN  = 6'b000100,
    S_MISS  = 6'b001000,
    S_FAIL0 = 6'b010000,
    S_ROUND = 6'b100000
  } state_t;

  state_t                  state;
  state_t                  state_next;
  cmd_t                    cmd;
  logic [IdxW-1:0]         idx;
  logic [IdxW-1:0]         idx_next;
  logic [NUM_SERVERS-1:0]  pending;
  logic [NUM_SERVERS-1:0]  pending_next;
  logic [NUM_SERVERS-1:0]  known;
  logic [NUM_SERVERS-1:0]  known_next;
  logic [RW-1:0]           cur_round;
  logic [RW-1:0]           cur_round_next;
  logic [RW-1:0]           next_round;
  logic [RW-1:0]           next_round_next;
  logic                    round_valid;
  logic                    round_valid_next;

  // Miss counter store; an entry is meaningful only while its known bit is set
  logic [CountW-1:0]       count_mem [NUM_SERVERS];
  logic [CountW-1:0]       rd_data;
  logic                    mem_we;
  logic [IdxW-1:0]         mem_waddr;
  logic [CountW-1:0]       mem_wdata;
  logic                    mem_re;
  logic [IdxW-1:0]         mem_raddr;

  logic                    emit;
  logic                    e_action;
  logic [3:0]              e_server;
  logic                    e_restart;
  logic [7:0]              e_round;
  logic                    e_last;

  logic                    slot_free;
  logic [IdxW-1:0]         ev_idx;
  logic [IdxW-1:0]         tgt;
  logic                    round_hit;
  logic [CountW-1:0]       cnt;
  logic [CountW-1:0]       cnt_inc;
  logic                    limit_hit;
  logic [CountW-1:0]       cnt_new;

  assign slot_free = !out_valid || !out_stall;
  assign ev_idx    = IdxW'(cmd.server);
  assign tgt       = (cmd.op == MODE_TICK) ? idx : ev_idx;
  assign round_hit = round_valid && (CmpW'(cmd.ping_id) == CmpW'(cur_round));

  // Miss arithmetic on the counter just read
  assign cnt       = known[tgt] ? rd_data : '0;
  assign cnt_inc   = (cnt != CountTop) ? cnt + 1'b1 : cnt;
  assign limit_hit = (cnt_inc >= fail_limit);
  assign cnt_new   = limit_hit ? '0 : cnt_inc;

  // Sequence one event, or sweep the table for a tick
  always_comb begin
    state_next       = state;
    idx_next         = idx;
    pending_next     = pending;
    known_next       = known;
    cur_round_next   = cur_round;
    next_round_next  = next_round;
    round_valid_next = round_valid;
    pop              = 1'b0;
    mem_we           = 1'b0;
    mem_waddr        = ev_idx;
    mem_wdata        = '0;
    mem_re           = 1'b0;
    mem_raddr        = ev_idx;
    emit             = 1'b0;
    e_action         = ACT_ERROR;
    e_server         = '0;
    e_restart        = 1'b0;
    e_round          = '0;
    e_last           = 1'b0;

    case (state)
      S_IDLE: begin
        if (head.valid) begin
          pop        = 1'b1;
          idx_next   = '0;
          state_next = S_EVAL;
        end
      end

      S_EVAL: begin
        state_next = S_IDLE;
        case (cmd.op)
          MODE_TICK: begin
            state_next = S_SCAN;
          end
          MODE_REMOVE: begin
            pending_next[ev_idx] = 1'b0;
            known_next[ev_idx]   = 1'b0;
          end
          MODE_PING: begin
            if (round_hit) begin
              pending_next[ev_idx] = 1'b1;
              if (!known[ev_idx]) begin
                known_next[ev_idx] = 1'b1;
                mem_we             = 1'b1;
              end
            end
          end
          MODE_FAIL: begin
            if (round_hit) begin
              if (known[ev_idx]) begin
                mem_re     = 1'b1;
                state_next = S_MISS;
              end else begin
                state_next = S_FAIL0;
              end
            end
          end
          MODE_ACK: begin
            if (round_hit) begin
              pending_next[ev_idx] = 1'b0;
              if (cmd.ack_ok) begin
                known_next[ev_idx] = 1'b1;
                mem_we             = 1'b1;
              end else begin
                mem_re     = 1'b1;
                state_next = S_MISS;
              end
            end
          end
          default: state_next = S_IDLE;
        endcase
      end

      S_SCAN: begin
        if (pending[idx]) begin
          mem_re     = 1'b1;
          mem_raddr  = idx;
          state_next = S_MISS;
        end else if (idx == LastIdx) begin
          state_next = S_ROUND;
        end else begin
          idx_next = IdxW'(idx + 1'b1);
        end
      end

      S_MISS: begin
        if (slot_free) begin
          emit            = 1'b1;
          e_server        = 4'(tgt);
          e_restart       = limit_hit;
          known_next[tgt] = 1'b1;
          mem_we          = 1'b1;
          mem_waddr       = tgt;
          mem_wdata       = cnt_new;
          if (cmd.op == MODE_TICK) begin
            pending_next[idx] = 1'b0;
            if (idx == LastIdx) begin
              state_next = S_ROUND;
            end else begin
              idx_next   = IdxW'(idx + 1'b1);
              state_next = S_SCAN;
            end
          end else begin
            e_last     = 1'b1;
            state_next = S_IDLE;
          end
        end
      end

      S_FAIL0: begin
        if (slot_free) begin
          emit               = 1'b1;
          e_server           = cmd.server;
          e_last             = 1'b1;
          known_next[ev_idx] = 1'b1;
          mem_we             = 1'b1;
          mem_wdata          = CountW'(1);
          state_next         = S_IDLE;
        end
      end

      S_ROUND: begin
        if (slot_free) begin
          emit             = 1'b1;
          e_action         = ACT_ROUND;
          e_round          = 8'(next_round);
          e_last           = 1'b1;
          cur_round_next   = next_round;
          next_round_next  = RW'(next_round + 1'b1);
          round_valid_next = 1'b1;
          state_next       = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  // Control and table flags
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      pending     <= '0;
      known       <= '0;
      cur_round   <= '0;
      next_round  <= '0;
      round_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      pending     <= pending_next;
      known       <= known_next;
      cur_round   <= cur_round_next;
      next_round  <= next_round_next;
      round_valid <= round_valid_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch the event word and the result word
  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head.cmd;
    end
    if (emit) begin
      action        <= e_action;
      server_id_out <= e_server;
      restart       <= e_restart;
      round_id      <= e_round;
      last          <= e_last;
    end
  end

  // Counter memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      count_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= count_mem[mem_raddr];
    end
  end

endmodule

// File: hdl/heartbeat_failure_monitor.sv
// Heartbeat supervisor for a table of servers.
// Input channel (in_valid / in_stall): one event word per transfer: mode
// (ping sent, ping failed, ack, removed, tick), server_id, ping_id, ack_ok.
// Output channel (out_valid / out_stall): result words; action 0 reports a
// server in error with its restart request, action 1 reports a new round id.
// The last word caused by one event has last set; many events cause none.
// Events go into a two-word queue, so the sender keeps going while the
// sequencer works. An event passes through S_IDLE and S_EVAL; one that
// reads a miss counter goes on to S_MISS, which uses the registered read of
// the counter memory. A tick scans the table one entry per cycle over servers
// with no pending ping; each pending one goes through S_MISS; S_ROUND ends it.
// When the receiver stalls, the word is held and the sequencer waits; once
// the queue fills, in_stall rises.
// Reset (rst, synchronous) clears the table flags, the round state and the
// queue, and sets fail_limit to 3. cfg_wr_en / cfg_wr_data write fail_limit;
// write it only while the block is idle.
module heartbeat_failure_monitor #(
  parameter int NUM_SERVERS    = 16,
  parameter int ROUND_ID_WIDTH = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] mode,
  input  logic [3:0] server_id,
  input  logic [7:0] ping_id,
  input  logic       ack_ok,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       action,
  output logic [3:0] server_id_out,
  output logic       restart,
  output logic [7:0] round_id,
  output logic       last
);
  import hfm_pkg::*;

  localparam logic [7:0] FailLimitReset = 8'd3;

  logic [7:0]  fail_limit;
  queue_head_t head;
  logic        pop;

  // Hold the miss limit
  always_ff @(posedge clk) begin
    if (rst) begin
      fail_limit <= FailLimitReset;
    end else if (cfg_wr_en) begin
      fail_limit <= cfg_wr_data;
    end
  end

  hfm_front #(
    .NUM_SERVERS (NUM_SERVERS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .server_id (server_id),
    .ping_id   (ping_id),
    .ack_ok    (ack_ok),
    .head      (head),
    .pop       (pop)
  );

  hfm_back #(
    .NUM_SERVERS    (NUM_SERVERS),
    .ROUND_ID_WIDTH (ROUND_ID_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .pop           (pop),
    .fail_limit    (fail_limit),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .action        (action),
    .server_id_out (server_id_out),
    .restart       (restart),
    .round_id      (round_id),
    .last          (last)
  );

endmodule
